>>> hdl/rfptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfptc_pkg
// Shared constants, register codes and transaction types for the pulse train
// capture block.
// ----------------------------------------------------------------------------
package rfptc_pkg;

   localparam int TRAIN_SLOTS_DEF = 4;
   localparam int MAX_PULSES_DEF  = 256;
   localparam int RSP_DEPTH       = 3;

   localparam int TIME_W     = 32;
   localparam int DUR_W      = 16;
   localparam int THR_W      = 20;
   localparam int LEN_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int RSP_DATA_W = 32;

   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [DUR_W-1:0] MIN_PULSE_RST = 16'd40;
   localparam logic [THR_W-1:0] MAX_PULSE_RST = 20'd100000;
   localparam logic [THR_W-1:0] GAP_RST       = 20'd5100;
   localparam logic [LEN_W-1:0] MIN_LEN_RST   = 9'd5;
   localparam logic [LEN_W-1:0] MAX_LEN_RST   = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE    = 3'd0,
      CSR_MIN_PULSE = 3'd1,
      CSR_MAX_PULSE = 3'd2,
      CSR_GAP       = 3'd3,
      CSR_MIN_LEN   = 3'd4,
      CSR_MAX_LEN   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic             enable;
      logic [DUR_W-1:0] min_pulse;
      logic [THR_W-1:0] max_pulse;
      logic [THR_W-1:0] gap;
      logic [LEN_W-1:0] min_len;
      logic [LEN_W-1:0] max_len;
   } cfg_type;

   typedef struct packed {
      logic             valid_res;
      logic             last;
      logic [LEN_W-1:0] train_length;
   } rsp_meta_type;

endpackage

>>> hdl/rfptc_pulse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfptc_pulse_ram
// Simple dual port pulse store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rfptc_pulse_ram #(
   parameter int DEPTH = rfptc_pkg::TRAIN_SLOTS_DEF * rfptc_pkg::MAX_PULSES_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [rfptc_pkg::DUR_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [rfptc_pkg::DUR_W-1:0]   rd_data
);

   logic [rfptc_pkg::DUR_W-1:0] mem_ff [DEPTH];
   logic [rfptc_pkg::DUR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rfptc_train_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfptc_train_ctrl
// Edge filtering, train framing and slot bookkeeping; drives the pulse store
// and the read stage that lines up with the store read data.
// ----------------------------------------------------------------------------
module rfptc_train_ctrl #(
   parameter int TRAIN_SLOTS = rfptc_pkg::TRAIN_SLOTS_DEF,
   parameter int MAX_PULSES  = rfptc_pkg::MAX_PULSES_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  rfptc_pkg::cfg_type                        cfg,
   input  logic                                      in_vld,
   input  logic                                      in_func,
   input  logic [rfptc_pkg::TIME_W-1:0]              in_time,
   output logic                                      mem_we,
   output logic [$clog2(TRAIN_SLOTS*MAX_PULSES)-1:0] mem_waddr,
   output logic [rfptc_pkg::DUR_W-1:0]               mem_wdata,
   output logic                                      mem_re,
   output logic [$clog2(TRAIN_SLOTS*MAX_PULSES)-1:0] mem_raddr,
   output logic                                      s1_vld,
   output rfptc_pkg::rsp_meta_type                   s1_meta
);

   localparam int SLOT_W = (TRAIN_SLOTS > 1) ? $clog2(TRAIN_SLOTS) : 1;
   localparam int PC_W   = $clog2(MAX_PULSES);
   localparam int ADDR_W = $clog2(TRAIN_SLOTS * MAX_PULSES);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TRAIN_SLOTS - 1);
   localparam logic [PC_W-1:0]   PC_LAST   = PC_W'(MAX_PULSES - 1);
   localparam logic [ADDR_W-1:0] SLOT_SIZE = ADDR_W'(MAX_PULSES);

   logic [TRAIN_SLOTS-1:0]        full_ff, full_in;
   logic [PC_W-1:0]               len_ff [TRAIN_SLOTS];
   logic [PC_W-1:0]               len_in [TRAIN_SLOTS];
   logic [SLOT_W-1:0]             ws_ff, ws_in;
   logic [SLOT_W-1:0]             rs_ff, rs_in;
   logic [PC_W-1:0]               pc_ff, pc_in;
   logic [PC_W-1:0]               off_ff, off_in;
   logic [rfptc_pkg::TIME_W-1:0]  last_time_ff, last_time_in;
   logic                          s1_vld_ff, s1_vld_in;
   rfptc_pkg::rsp_meta_type       s1_meta_ff, s1_meta_in;

   logic                          is_edge, is_read;
   logic [rfptc_pkg::TIME_W-1:0]  dur;
   logic                          edge_ok, store, gap_hit, keep;
   logic [PC_W-1:0]               pc_nxt;
   logic                          rd_hit, rd_last;
   logic [PC_W-1:0]               len_rd;
   logic [PC_W:0]                 off_nxt;

   assign is_edge = in_vld && (in_func == rfptc_pkg::FUNC_EDGE);
   assign is_read = in_vld && (in_func == rfptc_pkg::FUNC_READ);

   // elapsed time wraps modulo 2^32
   assign dur     = in_time - last_time_ff;
   assign edge_ok = is_edge && cfg.enable && !full_ff[ws_ff] &&
                    (dur > rfptc_pkg::TIME_W'(cfg.min_pulse));
   assign store   = edge_ok && (dur < rfptc_pkg::TIME_W'(cfg.max_pulse));
   assign gap_hit = store && (dur > rfptc_pkg::TIME_W'(cfg.gap));
   assign pc_nxt  = (pc_ff == PC_LAST) ? '0 : pc_ff + 1'b1;
   // a train whose count wrapped to zero is not kept, so it is lost
   assign keep    = gap_hit && (pc_nxt != '0) &&
                    (rfptc_pkg::TIME_W'(pc_nxt) >= rfptc_pkg::TIME_W'(cfg.min_len)) &&
                    (rfptc_pkg::TIME_W'(pc_nxt) <= rfptc_pkg::TIME_W'(cfg.max_len));

   assign rd_hit  = is_read && full_ff[rs_ff];
   assign len_rd  = len_ff[rs_ff];
   assign off_nxt = {1'b0, off_ff} + 1'b1;
   assign rd_last = off_nxt >= {1'b0, len_rd};

   assign mem_we    = store;
   assign mem_waddr = ADDR_W'(ws_ff) * SLOT_SIZE + ADDR_W'(pc_ff);
   assign mem_wdata = dur[rfptc_pkg::DUR_W-1:0];
   assign mem_re    = rd_hit;
   assign mem_raddr = ADDR_W'(rs_ff) * SLOT_SIZE + ADDR_W'(off_ff);

   always_comb begin
      full_in      = full_ff;
      len_in       = len_ff;
      ws_in        = ws_ff;
      rs_in        = rs_ff;
      pc_in        = pc_ff;
      off_in       = off_ff;
      last_time_in = last_time_ff;
      if (edge_ok) begin
         last_time_in = in_time;
      end
      if (store) begin
         pc_in = gap_hit ? '0 : pc_nxt;
      end
      if (keep) begin
         full_in[ws_ff] = 1'b1;
         len_in[ws_ff]  = pc_nxt;
         ws_in          = (ws_ff == SLOT_LAST) ? '0 : ws_ff + 1'b1;
      end
      if (rd_hit) begin
         if (rd_last) begin
            full_in[rs_ff] = 1'b0;
            rs_in          = (rs_ff == SLOT_LAST) ? '0 : rs_ff + 1'b1;
            off_in         = '0;
         end else begin
            off_in = off_nxt[PC_W-1:0];
         end
      end
   end

   always_comb begin
      s1_vld_in               = is_read;
      s1_meta_in.valid_res    = rd_hit;
      s1_meta_in.last         = rd_hit && rd_last;
      s1_meta_in.train_length = rd_hit ? rfptc_pkg::LEN_W'(len_rd) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= '0;
         ws_ff        <= '0;
         rs_ff        <= '0;
         pc_ff        <= '0;
         off_ff       <= '0;
         last_time_ff <= '0;
         s1_vld_ff    <= 1'b0;
      end else begin
         full_ff      <= full_in;
         ws_ff        <= ws_in;
         rs_ff        <= rs_in;
         pc_ff        <= pc_in;
         off_ff       <= off_in;
         last_time_ff <= last_time_in;
         s1_vld_ff    <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      s1_meta_ff <= s1_meta_in;
   end

   assign s1_vld  = s1_vld_ff;
   assign s1_meta = s1_meta_ff;

   // a full read slot is never overwritten by the capture side
   a_no_write_into_full_read_slot: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !(full_ff[rs_ff] && (ws_ff == rs_ff)))
      else $error("pulse write into a full read slot");

   a_last_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (rd_hit && rd_last) |=> !full_ff[$past(rs_ff)])
      else $error("slot not freed after final pulse");

   a_last_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_meta_ff.last) |-> s1_meta_ff.valid_res)
      else $error("last flag on a read without a train");

endmodule

>>> hdl/rfptc_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfptc_rsp_fifo
// Small response queue between the store read stage and the result channel.
// ----------------------------------------------------------------------------
module rfptc_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [rfptc_pkg::DUR_W-1:0]   push_dur,
   input  rfptc_pkg::rsp_meta_type       push_meta,
   input  logic                          pop_ready,
   output logic                          out_vld,
   output logic [rfptc_pkg::DUR_W-1:0]   out_dur,
   output rfptc_pkg::rsp_meta_type       out_meta,
   output logic                          room
);

   localparam int DEPTH = rfptc_pkg::RSP_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [rfptc_pkg::DUR_W-1:0] dur_ff [DEPTH];
   rfptc_pkg::rsp_meta_type     meta_ff [DEPTH];
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        pop;
   logic [CNT_W:0]              pend;

   assign out_vld  = cnt_ff != '0;
   assign out_dur  = dur_ff[rd_ptr_ff];
   assign out_meta = meta_ff[rd_ptr_ff];
   assign pop      = out_vld && pop_ready;

   // a read in the store stage already holds a place
   assign pend = {1'b0, cnt_ff} + (CNT_W + 1)'(push);
   assign room = pend < (CNT_W + 1)'(DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         dur_ff[wr_ptr_ff]  <= push_dur;
         meta_ff[wr_ptr_ff] <= push_meta;
      end
   end

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("response queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && (cnt_ff == CNT_FULL)) |-> pop)
      else $error("response queue overflow");

endmodule

>>> hdl/rf_pulse_train_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_pulse_train_capture
// Captures on-off keyed pulse trains from edge timestamps, frames them by
// long gaps and hands stored pulses back one per read transaction.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata timestamp_us, tuser func
//   rsp      out  rsp_tvalid/rsp_tready  tdata duration+length, tuser valid_res,
//                                        tlast last
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// one req transaction per cycle while req_tready is high; an edge never
// yields a response; a read's response is registered before it is shown:
// the pulse store read registers at the accepting edge, then the response
// queue takes it; req_tready falls when the responses in the three-entry
// queue and a read in the store read stage add up to three, so a stalled
// rsp side stalls req after three reads; csr writes act in the next cycle
// synchronous reset, no clearing pass: slot state sits in flip-flops
// ----------------------------------------------------------------------------
module rf_pulse_train_capture #(
   parameter int TRAIN_SLOTS = rfptc_pkg::TRAIN_SLOTS_DEF,
   parameter int MAX_PULSES  = rfptc_pkg::MAX_PULSES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rfptc_pkg::TIME_W-1:0]         req_tdata,  // [31:0] timestamp_us
   input  logic                                 req_tuser,  // [0] func
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] pulse_duration, [24:16] train_length, [31:25] zero
   output logic [rfptc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,  // [0] valid_res
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rfptc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rfptc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int ADDR_W = $clog2(TRAIN_SLOTS * MAX_PULSES);
   localparam int PAD_W  = rfptc_pkg::RSP_DATA_W - rfptc_pkg::DUR_W - rfptc_pkg::LEN_W;

   rfptc_pkg::cfg_type           cfg_ff, cfg_in;
   logic                         in_vld;
   logic                         mem_we, mem_re;
   logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
   logic [rfptc_pkg::DUR_W-1:0]  mem_wdata, mem_rdata;
   logic                         s1_vld;
   rfptc_pkg::rsp_meta_type      s1_meta;
   logic [rfptc_pkg::DUR_W-1:0]  push_dur;
   logic                         room;
   logic [rfptc_pkg::DUR_W-1:0]  out_dur;
   rfptc_pkg::rsp_meta_type      out_meta;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rfptc_pkg::CSR_ENABLE:    cfg_in.enable    = csr_data[0];
            rfptc_pkg::CSR_MIN_PULSE: cfg_in.min_pulse = csr_data[rfptc_pkg::DUR_W-1:0];
            rfptc_pkg::CSR_MAX_PULSE: cfg_in.max_pulse = csr_data[rfptc_pkg::THR_W-1:0];
            rfptc_pkg::CSR_GAP:       cfg_in.gap       = csr_data[rfptc_pkg::THR_W-1:0];
            rfptc_pkg::CSR_MIN_LEN:   cfg_in.min_len   = csr_data[rfptc_pkg::LEN_W-1:0];
            rfptc_pkg::CSR_MAX_LEN:   cfg_in.max_len   = csr_data[rfptc_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= 1'b0;
         cfg_ff.min_pulse <= rfptc_pkg::MIN_PULSE_RST;
         cfg_ff.max_pulse <= rfptc_pkg::MAX_PULSE_RST;
         cfg_ff.gap       <= rfptc_pkg::GAP_RST;
         cfg_ff.min_len   <= rfptc_pkg::MIN_LEN_RST;
         cfg_ff.max_len   <= rfptc_pkg::MAX_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = room;
   assign in_vld     = req_tvalid && req_tready;

   rfptc_train_ctrl #(
      .TRAIN_SLOTS (TRAIN_SLOTS),
      .MAX_PULSES  (MAX_PULSES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_vld    (in_vld),
      .in_func   (req_tuser),
      .in_time   (req_tdata),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .s1_vld    (s1_vld),
      .s1_meta   (s1_meta)
   );

   rfptc_pulse_ram #(
      .DEPTH (TRAIN_SLOTS * MAX_PULSES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // empty reads return all-zero fields
   assign push_dur = s1_meta.valid_res ? mem_rdata : '0;

   rfptc_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_vld),
      .push_dur  (push_dur),
      .push_meta (s1_meta),
      .pop_ready (rsp_tready),
      .out_vld   (rsp_tvalid),
      .out_dur   (out_dur),
      .out_meta  (out_meta),
      .room      (room)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, out_meta.train_length, out_dur};
   assign rsp_tuser = out_meta.valid_res;
   assign rsp_tlast = out_meta.last;

endmodule

>>> verif/rf_pulse_train_capture_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_pulse_train_capture_tb
// Self-checking bench for the pulse train capture block. A short directed
// table covers the disabled receiver, the out-of-band durations, the
// timestamp wrap, truncation to 16 bits, a full set of slots and reads with
// no train ready. Random phases with fresh register settings then send
// well-formed pulse trains, broken trains, noise edges and reads. A
// behavioural copy of the capture logic predicts each read response, and
// both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module rf_pulse_train_capture_tb;

   localparam int SLOT_W       = $clog2(rfptc_pkg::TRAIN_SLOTS_DEF);
   localparam int COUNT_W      = $clog2(rfptc_pkg::MAX_PULSES_DEF);
   localparam int N_PLAN       = 27;
   localparam int RANDOM_ITEMS = 1500;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [rfptc_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   typedef struct packed {
      logic                        valid_res;
      logic [rfptc_pkg::DUR_W-1:0] duration;
      logic                        last;
      logic [rfptc_pkg::LEN_W-1:0] length;
   } pulse_rsp_type;

   typedef enum logic [1:0] {ROW_EDGE, ROW_READ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [rfptc_pkg::TIME_W-1:0]    arg;
      logic [rfptc_pkg::CSR_IDX_W-1:0] idx;
      logic                            typed;
      pulse_rsp_type                   rsp;
   } plan_row_type;

   localparam pulse_rsp_type NO_TRAIN = '0;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [rfptc_pkg::TIME_W-1:0]     req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [rfptc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [rfptc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rfptc_pkg::CSR_DATA_W-1:0] csr_data;

   // predicted capture state
   rfptc_pkg::cfg_type          model_cfg;
   logic [rfptc_pkg::DUR_W-1:0] model_store
                                   [0:rfptc_pkg::TRAIN_SLOTS_DEF*rfptc_pkg::MAX_PULSES_DEF-1];
   logic [rfptc_pkg::LEN_W-1:0] model_len [0:rfptc_pkg::TRAIN_SLOTS_DEF-1];
   logic [SLOT_W-1:0]            model_wr_slot;
   logic [SLOT_W-1:0]            model_rd_slot;
   logic [COUNT_W-1:0]           model_count;
   logic [COUNT_W-1:0]           model_offset;
   logic [rfptc_pkg::TIME_W-1:0] model_last_edge;

   pulse_rsp_type expected_pulses [$];
   int            errors = 0;
   int            items_done = 0;
   int            offered = 0;
   int            rsp_count = 0;
   bit            req_burst = 1'b0;
   bit            rsp_burst = 1'b0;

   plan_row_type directed_plan [N_PLAN] = '{
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b1, NO_TRAIN},
      '{ROW_EDGE, 32'h0000_03E8, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_CSR,  32'h000F_FFFF, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_CSR,  32'h0000_0001, rfptc_pkg::CSR_MIN_LEN, 1'b0, NO_TRAIN},
      '{ROW_CSR,  32'h000F_FFFF, CSR_UNUSED_IDX, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'hFFFF_FF00, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0000_0010, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0000_0038, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0000_0039, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0000_1425, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0000_2812, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'hFFFF_FFFF, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b1, NO_TRAIN},
      '{ROW_EDGE, 32'h0001_2812, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0002_AEB1, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0004_3551, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0005_3550, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0006_46C0, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_EDGE, 32'h0006_5E30, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b0, NO_TRAIN},
      '{ROW_READ, 32'h0000_0000, rfptc_pkg::CSR_ENABLE, 1'b1, NO_TRAIN}
   };

   rf_pulse_train_capture dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // one accepted transaction; returns 1 when a read response is due
   function automatic bit capture_step(input logic func,
                                       input logic [rfptc_pkg::TIME_W-1:0] stamp,
                                       output pulse_rsp_type rsp);
      logic [rfptc_pkg::TIME_W-1:0] elapsed;
      logic [COUNT_W-1:0]           next_count;
      logic [rfptc_pkg::LEN_W-1:0]  len;
      rsp = NO_TRAIN;
      if (func == rfptc_pkg::FUNC_EDGE) begin
         if (model_cfg.enable && model_len[model_wr_slot] == 0) begin
            elapsed = stamp - model_last_edge;
            if (elapsed > model_cfg.min_pulse) begin
               if (elapsed < model_cfg.max_pulse) begin
                  model_store[{model_wr_slot, model_count}] = elapsed[rfptc_pkg::DUR_W-1:0];
                  next_count = model_count + 1'b1;
                  model_count = next_count;
                  if (elapsed > model_cfg.gap) begin
                     // a count wrapped to zero would look like a free slot
                     if (next_count != 0 && next_count >= model_cfg.min_len &&
                         next_count <= model_cfg.max_len) begin
                        model_len[model_wr_slot] = rfptc_pkg::LEN_W'(next_count);
                        model_wr_slot = model_wr_slot + 1'b1;
                     end
                     model_count = '0;
                  end
               end
               model_last_edge = stamp;
            end
         end
         return 1'b0;
      end
      len = model_len[model_rd_slot];
      if (len != 0) begin
         rsp.valid_res = 1'b1;
         rsp.duration  = model_store[{model_rd_slot, model_offset}];
         rsp.length    = len;
         if (rfptc_pkg::LEN_W'(model_offset) + 1 >= len) begin
            rsp.last = 1'b1;
            model_len[model_rd_slot] = '0;
            model_rd_slot = model_rd_slot + 1'b1;
            model_offset = '0;
         end else begin
            model_offset = model_offset + 1'b1;
         end
      end
      return 1'b1;
   endfunction

   function automatic int unsigned draw_between(input longint lo, input longint hi);
      if (lo > hi)
         return $urandom_range(0, 200000);
      if (hi - lo > 3000 && $urandom_range(0, 1) == 0)
         return 32'(lo + longint'($urandom_range(0, 3000)));
      return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
   endfunction

   task automatic offer_item(input logic func, input logic [rfptc_pkg::TIME_W-1:0] stamp,
                             input logic typed, input pulse_rsp_type typed_rsp);
      int            idle_cycles;
      pulse_rsp_type predicted;
      idle_cycles = req_burst ? 0 : $urandom_range(0, 13);
      if (idle_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= stamp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_done++;
      if (capture_step(func, stamp, predicted))
         expected_pulses.push_back(typed ? typed_rsp : predicted);
      offered++;
      if (offered % 32 == 0)
         req_burst = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_edge(input int unsigned span);
      offer_item(rfptc_pkg::FUNC_EDGE, model_last_edge + span, 1'b0, NO_TRAIN);
   endtask

   task automatic send_reads(input int count);
      repeat (count) offer_item(rfptc_pkg::FUNC_READ, $urandom, 1'b0, NO_TRAIN);
   endtask

   // pulses inside the band and not above the gap, then one gap pulse if closed
   task automatic send_train(input int pulses, input bit closed);
      longint lo_p, hi_p, lo_g, hi_g;
      lo_p = longint'(model_cfg.min_pulse) + 1;
      hi_p = longint'(model_cfg.max_pulse) - 1;
      if (longint'(model_cfg.gap) < hi_p)
         hi_p = longint'(model_cfg.gap);
      lo_g = (longint'(model_cfg.gap) > longint'(model_cfg.min_pulse) ?
              longint'(model_cfg.gap) : longint'(model_cfg.min_pulse)) + 1;
      hi_g = longint'(model_cfg.max_pulse) - 1;
      for (int p = 1; p < pulses; p++) begin
         if ($urandom_range(0, 11) == 0)
            send_reads(1);
         send_edge(draw_between(lo_p, hi_p));
      end
      if (closed)
         send_edge(draw_between(lo_g, hi_g));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pulses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rfptc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rfptc_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         rfptc_pkg::CSR_ENABLE:    model_cfg.enable    = value[0];
         rfptc_pkg::CSR_MIN_PULSE: model_cfg.min_pulse = value[rfptc_pkg::DUR_W-1:0];
         rfptc_pkg::CSR_MAX_PULSE: model_cfg.max_pulse = value[rfptc_pkg::THR_W-1:0];
         rfptc_pkg::CSR_GAP:       model_cfg.gap       = value[rfptc_pkg::THR_W-1:0];
         rfptc_pkg::CSR_MIN_LEN:   model_cfg.min_len   = value[rfptc_pkg::LEN_W-1:0];
         rfptc_pkg::CSR_MAX_LEN:   model_cfg.max_len   = value[rfptc_pkg::LEN_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // response side: random stalls, occasional long hold, checking
   initial begin : rsp_side
      int            stall;
      int            hold_at;
      pulse_rsp_type got;
      pulse_rsp_type want;
      rsp_tready = 1'b0;
      hold_at = 40;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_count >= hold_at) begin
            stall = HOLD_CYCLES;
            hold_at = rsp_count + $urandom_range(300, 700);
         end else begin
            stall = rsp_burst ? 0 : $urandom_range(0, 13);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.valid_res = rsp_tuser;
         got.duration  = rsp_tdata[rfptc_pkg::DUR_W-1:0];
         got.length    = rsp_tdata[rfptc_pkg::DUR_W+rfptc_pkg::LEN_W-1:rfptc_pkg::DUR_W];
         got.last      = rsp_tlast;
         if (expected_pulses.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected rsp transaction: valid_res %0d duration %0d last %0d length %0d",
                        got.valid_res, got.duration, got.last, got.length);
         end else begin
            want = expected_pulses.pop_front();
            if (got !== want ||
                rsp_tdata[rfptc_pkg::RSP_DATA_W-1:rfptc_pkg::DUR_W+rfptc_pkg::LEN_W] !== '0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("rsp mismatch: exp valid_res %0d duration %0d last %0d length %0d, %s",
                           want.valid_res, want.duration, want.last, want.length,
                           $sformatf("got %0d %0d %0d %0d pad %0h", got.valid_res, got.duration,
                                     got.last, got.length,
                                     rsp_tdata[rfptc_pkg::RSP_DATA_W-1:
                                               rfptc_pkg::DUR_W+rfptc_pkg::LEN_W]));
            end
         end
         rsp_count++;
         if (rsp_count % 32 == 0)
            rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : req_side
      plan_row_type row;
      int           en, min_p, max_p, gap_p, min_l, max_l, n;
      bit           first_phase;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rfptc_pkg::FUNC_EDGE;
      csr_valid  = 1'b0;
      csr_index  = rfptc_pkg::CSR_ENABLE;
      csr_data   = '0;
      model_cfg.enable    = 1'b0;
      model_cfg.min_pulse = rfptc_pkg::MIN_PULSE_RST;
      model_cfg.max_pulse = rfptc_pkg::MAX_PULSE_RST;
      model_cfg.gap       = rfptc_pkg::GAP_RST;
      model_cfg.min_len   = rfptc_pkg::MIN_LEN_RST;
      model_cfg.max_len   = rfptc_pkg::MAX_LEN_RST;
      foreach (model_len[s]) model_len[s] = '0;
      model_wr_slot   = '0;
      model_rd_slot   = '0;
      model_count     = '0;
      model_offset    = '0;
      model_last_edge = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         row = directed_plan[r];
         if (row.kind == ROW_CSR) begin
            settle();
            write_csr(row.idx, row.arg[rfptc_pkg::CSR_DATA_W-1:0]);
         end else begin
            offer_item(row.kind == ROW_READ ? rfptc_pkg::FUNC_READ : rfptc_pkg::FUNC_EDGE,
                       row.arg, row.typed, row.rsp);
         end
      end

      first_phase = 1'b1;
      while (items_done < N_PLAN + RANDOM_ITEMS) begin
         settle();
         en = ($urandom_range(0, 7) != 0);
         case ($urandom_range(0, 9))
            0: min_p = 0;
            1: min_p = 65535;
            default: min_p = $urandom_range(0, 300);
         endcase
         case ($urandom_range(0, 9))
            0: max_p = 0;
            1, 2: max_p = 20'hFFFFF;
            default: max_p = $urandom_range(min_p + 3000, 200000);
         endcase
         case ($urandom_range(0, 9))
            0: gap_p = 0;
            1: gap_p = 20'hFFFFF;
            default: gap_p = min_p + $urandom_range(500, 20000);
         endcase
         case ($urandom_range(0, 9))
            0: min_l = 0;
            1: min_l = 256;
            default: min_l = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 9))
            0: max_l = 0;
            1, 2: max_l = 256;
            default: max_l = min_l + $urandom_range(0, 12);
         endcase
         if (max_l > 256)
            max_l = 256;
         if (first_phase) begin
            // widest limits so the count wrap and the longest train are seen
            en = 1;
            min_p = $urandom_range(0, 300);
            max_p = 20'hFFFFF;
            gap_p = min_p + 5000;
            min_l = 0;
            max_l = 256;
         end
         write_csr(rfptc_pkg::CSR_ENABLE, rfptc_pkg::CSR_DATA_W'(en));
         write_csr(rfptc_pkg::CSR_MIN_PULSE, rfptc_pkg::CSR_DATA_W'(min_p));
         write_csr(rfptc_pkg::CSR_MAX_PULSE, rfptc_pkg::CSR_DATA_W'(max_p));
         write_csr(rfptc_pkg::CSR_GAP, rfptc_pkg::CSR_DATA_W'(gap_p));
         write_csr(rfptc_pkg::CSR_MIN_LEN, rfptc_pkg::CSR_DATA_W'(min_l));
         write_csr(rfptc_pkg::CSR_MAX_LEN, rfptc_pkg::CSR_DATA_W'(max_l));
         if (first_phase) begin
            send_train(rfptc_pkg::MAX_PULSES_DEF, 1'b1);
            send_train(rfptc_pkg::MAX_PULSES_DEF - 1, 1'b1);
            send_reads(rfptc_pkg::MAX_PULSES_DEF);
            first_phase = 1'b0;
         end else begin
            repeat ($urandom_range(10, 25)) begin
               case ($urandom_range(0, 17))
                  12, 13: send_reads($urandom_range(1, 6));
                  14: offer_item(rfptc_pkg::FUNC_EDGE, $urandom, 1'b0, NO_TRAIN);
                  15: send_edge($urandom_range(0, model_cfg.min_pulse));
                  16: send_edge(model_cfg.max_pulse + $urandom_range(0, 5000));
                  17: send_train($urandom_range(1, 8), 1'b0);
                  default: begin
                     if (model_cfg.min_len > 40 || $urandom_range(0, 3) == 0)
                        n = $urandom_range(1, 16);
                     else
                        n = model_cfg.min_len + $urandom_range(0, 6);
                     if (n == 0)
                        n = 1;
                     send_train(n, 1'b1);
                     if ($urandom_range(0, 3) != 0)
                        send_reads(n + $urandom_range(0, 1));
                  end
               endcase
            end
         end
      end

      req_tvalid <= 1'b0;
      while (expected_pulses.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
